[hdl/ccb_pkg.sv]
package ccb_pkg;

  localparam int CANVAS_WIDTH = 320;
  localparam int CANVAS_HEIGHT = 240;
  localparam int FIFO_DEPTH = 2;

  localparam int ADDR_W = 17;
  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;

  localparam logic [2:0] REG_BLEND_MODE = 3'd0;
  localparam logic [2:0] REG_KEY_COLOR = 3'd1;
  localparam logic [2:0] REG_SECOND_KEY_COLOR = 3'd2;
  localparam logic [2:0] REG_FILL_COLOR = 3'd3;
  localparam logic [2:0] REG_SOURCE_WIDTH = 3'd4;
  localparam logic [2:0] REG_SOURCE_HEIGHT = 3'd5;

  localparam logic [1:0] MODE_COPY = 2'd0;
  localparam logic [1:0] MODE_KEY = 2'd1;
  localparam logic [1:0] MODE_RECOLOR = 2'd2;

  localparam logic REQ_COMMAND = 1'b0;
  localparam logic REQ_PIXEL = 1'b1;

  typedef struct packed {
    logic req_type;
    logic signed [11:0] dest_x;
    logic signed [11:0] dest_y;
    logic [10:0] copy_width;
    logic [10:0] copy_height;
    logic [9:0] origin_x;
    logic [9:0] origin_y;
    logic [7:0] src_pixel;
  } req_t;

  typedef struct packed {
    logic resp_kind;
    logic accepted;
    logic [8:0] clipped_dest_x;
    logic [7:0] clipped_dest_y;
    logic [8:0] clipped_width;
    logic [7:0] clipped_height;
    logic [11:0] clipped_origin_x;
    logic [11:0] clipped_origin_y;
    logic write_enable;
    logic [ADDR_W-1:0] write_addr;
    logic [7:0] write_color;
    logic last;
  } resp_t;

  typedef struct packed {
    logic [1:0] blend_mode;
    logic [7:0] key_color;
    logic [7:0] second_key_color;
    logic [7:0] fill_color;
    logic [10:0] source_width;
    logic [10:0] source_height;
  } cfg_t;

  typedef struct packed {
    logic is_pixel;
    logic accepted;
    logic [8:0] dest_x;
    logic [7:0] dest_y;
    logic [8:0] width;
    logic [7:0] height;
    logic [11:0] origin_x;
    logic [11:0] origin_y;
    logic [ADDR_W-1:0] start_addr;
    logic [7:0] pixel;
  } entry_t;

endpackage

[hdl/ccb_cfg.sv]
module ccb_cfg
  import ccb_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg
);

  logic [2:0] index;
  logic       wr;

  assign index = paddr[4:2];
  assign wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.blend_mode <= MODE_KEY;
      cfg.key_color <= 8'd0;
      cfg.second_key_color <= 8'd0;
      cfg.fill_color <= 8'd0;
      cfg.source_width <= 11'd256;
      cfg.source_height <= 11'd256;
    end else if (wr) begin
      case (index)
        REG_BLEND_MODE: cfg.blend_mode <= pwdata[1:0];
        REG_KEY_COLOR: cfg.key_color <= pwdata[7:0];
        REG_SECOND_KEY_COLOR: cfg.second_key_color <= pwdata[7:0];
        REG_FILL_COLOR: cfg.fill_color <= pwdata[7:0];
        REG_SOURCE_WIDTH: cfg.source_width <= pwdata[10:0];
        REG_SOURCE_HEIGHT: cfg.source_height <= pwdata[10:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (index)
      REG_BLEND_MODE: prdata = {30'd0, cfg.blend_mode};
      REG_KEY_COLOR: prdata = {24'd0, cfg.key_color};
      REG_SECOND_KEY_COLOR: prdata = {24'd0, cfg.second_key_color};
      REG_FILL_COLOR: prdata = {24'd0, cfg.fill_color};
      REG_SOURCE_WIDTH: prdata = {21'd0, cfg.source_width};
      REG_SOURCE_HEIGHT: prdata = {21'd0, cfg.source_height};
      default: prdata = '0;
    endcase
  end

endmodule

[hdl/ccb_front.sv]
module ccb_front
  import ccb_pkg::*;
(
  input  req_t   req,
  input  logic   push,
  input  cfg_t   cfg,
  output logic   wr_en,
  output entry_t entry
);

  typedef struct packed {
    logic ok;
    logic signed [13:0] pos;
    logic signed [13:0] len;
    logic signed [13:0] org;
  } axis_t;

  localparam logic signed [13:0] LIMIT_X = 14'(CANVAS_WIDTH);
  localparam logic signed [13:0] LIMIT_Y = 14'(CANVAS_HEIGHT);

  function automatic axis_t clip_axis(input logic signed [13:0] pos,
                                      input logic signed [13:0] len,
                                      input logic signed [13:0] org,
                                      input logic signed [13:0] limit);
    axis_t r;
    logic signed [13:0] p;
    logic signed [13:0] l;
    logic signed [13:0] o;
    p = pos;
    l = len;
    o = org;
    r.ok = 1'b1;
    if ((p + l < 14'sd0) || (p >= limit)) r.ok = 1'b0;
    if (p < 14'sd0) begin
      o = o - p;
      l = l + p;
      p = 14'sd0;
    end
    if (l <= 14'sd0) r.ok = 1'b0;
    if (p + l >= limit) l = limit - p;
    r.pos = p;
    r.len = l;
    r.org = o;
    return r;
  endfunction

  logic [10:0]       w;
  logic [10:0]       h;
  axis_t             cx;
  axis_t             cy;
  logic              ok;
  logic [ADDR_W-1:0] row_off;

  always_comb begin
    w = ((req.copy_width == 11'd0) || (req.copy_width > cfg.source_width)) ?
        cfg.source_width : req.copy_width;
    h = ((req.copy_height == 11'd0) || (req.copy_height > cfg.source_height)) ?
        cfg.source_height : req.copy_height;
    cx = clip_axis({{2{req.dest_x[11]}}, req.dest_x}, {3'd0, w},
                   {4'd0, req.origin_x}, LIMIT_X);
    cy = clip_axis({{2{req.dest_y[11]}}, req.dest_y}, {3'd0, h},
                   {4'd0, req.origin_y}, LIMIT_Y);
    ok = cx.ok && cy.ok;
    row_off = ADDR_W'(cy.pos[7:0]) * ADDR_W'(CANVAS_WIDTH);

    entry = '0;
    entry.is_pixel = req.req_type;
    entry.pixel = req.src_pixel;
    if (ok) begin
      entry.accepted = 1'b1;
      entry.dest_x = cx.pos[8:0];
      entry.dest_y = cy.pos[7:0];
      entry.width = cx.len[8:0];
      entry.height = cy.len[7:0];
      entry.origin_x = cx.org[11:0];
      entry.origin_y = cy.org[11:0];
      entry.start_addr = ADDR_W'(cx.pos[8:0]) + row_off;
    end
  end

  assign wr_en = push;

endmodule

[hdl/ccb_fifo.sv]
module ccb_fifo
  import ccb_pkg::*;
#(
  parameter int DEPTH = FIFO_DEPTH
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   wr_en,
  input  entry_t wr_data,
  output logic   full,
  input  logic   rd_en,
  output entry_t rd_data,
  output logic   empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  entry_t           store [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign full = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign do_wr = wr_en && !full;
  assign do_rd = rd_en && !empty;
  assign rd_data = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) store[wr_ptr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_wr) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (do_rd) rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (do_wr && !do_rd) count <= count + 1'b1;
      else if (do_rd && !do_wr) count <= count - 1'b1;
    end
  end

endmodule

[hdl/ccb_back.sv]
module ccb_back
  import ccb_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  cfg_t   cfg,
  input  entry_t entry,
  input  logic   fifo_empty,
  output logic   fifo_rd,
  output resp_t  resp,
  output logic   empty,
  input  logic   pop
);

  logic              busy;
  logic [8:0]        rect_width;
  logic [7:0]        rect_height;
  logic [8:0]        column_count;
  logic [7:0]        row_count;
  logic [ADDR_W-1:0] row_start_addr;
  logic [ADDR_W-1:0] cursor_addr;
  logic              out_valid;

  logic              busy_next;
  logic [8:0]        rect_width_next;
  logic [7:0]        rect_height_next;
  logic [8:0]        column_count_next;
  logic [7:0]        row_count_next;
  logic [ADDR_W-1:0] row_start_addr_next;
  logic [ADDR_W-1:0] cursor_addr_next;
  resp_t             resp_next;

  logic              take;
  logic              we;
  logic [7:0]        color;
  logic              is_last;
  logic [9:0]        col_inc;

  assign take = !fifo_empty && (!out_valid || pop);
  assign fifo_rd = take;
  assign empty = !out_valid;

  always_comb begin
    case (cfg.blend_mode)
      MODE_COPY: begin
        we = 1'b1;
        color = entry.pixel;
      end
      MODE_RECOLOR: begin
        we = (entry.pixel != cfg.key_color);
        color = !we ? 8'd0 :
                (entry.pixel == cfg.second_key_color) ? entry.pixel : cfg.fill_color;
      end
      default: begin
        we = (entry.pixel != cfg.key_color);
        color = we ? entry.pixel : 8'd0;
      end
    endcase

    col_inc = {1'b0, column_count} + 10'd1;
    is_last = (col_inc >= {1'b0, rect_width}) &&
              ({1'b0, row_count} + 9'd1 >= {1'b0, rect_height});

    busy_next = busy;
    rect_width_next = rect_width;
    rect_height_next = rect_height;
    column_count_next = column_count;
    row_count_next = row_count;
    row_start_addr_next = row_start_addr;
    cursor_addr_next = cursor_addr;
    resp_next = '0;

    if (!entry.is_pixel) begin
      resp_next.resp_kind = REQ_COMMAND;
      resp_next.accepted = entry.accepted;
      resp_next.clipped_dest_x = entry.dest_x;
      resp_next.clipped_dest_y = entry.dest_y;
      resp_next.clipped_width = entry.width;
      resp_next.clipped_height = entry.height;
      resp_next.clipped_origin_x = entry.origin_x;
      resp_next.clipped_origin_y = entry.origin_y;
      busy_next = entry.accepted;
      column_count_next = 9'd0;
      row_count_next = 8'd0;
      rect_width_next = entry.width;
      rect_height_next = entry.height;
      row_start_addr_next = entry.start_addr;
      cursor_addr_next = entry.start_addr;
    end else begin
      resp_next.resp_kind = REQ_PIXEL;
      if (busy) begin
        resp_next.write_enable = we;
        resp_next.write_addr = cursor_addr;
        resp_next.write_color = color;
        resp_next.last = is_last;
        column_count_next = col_inc[8:0];
        cursor_addr_next = cursor_addr + 1'b1;
        if (col_inc >= {1'b0, rect_width}) begin
          column_count_next = 9'd0;
          row_count_next = row_count + 1'b1;
          row_start_addr_next = row_start_addr + ADDR_W'(CANVAS_WIDTH);
          cursor_addr_next = row_start_addr + ADDR_W'(CANVAS_WIDTH);
        end
        if (is_last) begin
          busy_next = 1'b0;
          column_count_next = 9'd0;
          row_count_next = 8'd0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      rect_width <= '0;
      rect_height <= '0;
      column_count <= '0;
      row_count <= '0;
      row_start_addr <= '0;
      cursor_addr <= '0;
      out_valid <= 1'b0;
    end else begin
      if (take) begin
        busy <= busy_next;
        rect_width <= rect_width_next;
        rect_height <= rect_height_next;
        column_count <= column_count_next;
        row_count <= row_count_next;
        row_start_addr <= row_start_addr_next;
        cursor_addr <= cursor_addr_next;
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) resp <= resp_next;
  end

endmodule

[hdl/clipped_color_key_blitter.sv]
// Clipped color-key blitter on a fixed-size canvas.
// Items enter through a queue-style port: a transaction happens when push is
// high and full is low. A command item clips a copy rectangle to the canvas;
// the following pixel items carry the clipped source pixels in raster order.
// Each item gives exactly one result, read through the second queue-style
// port: the oldest result is on resp while empty is low, and a transaction
// happens when pop is high and empty is low.
// The front stage clips the command in the cycle of acceptance and writes a
// small queue; the back stage walks the rectangle and fills the output
// register. A result reaches resp through the queue and the output register,
// and one item per cycle is sustained while pop stays high, set by the
// one-pixel-per-cycle back stage. When the receiver stalls, the output
// register and then the queue fill up, and full rises until pop resumes.
// Configuration registers are to be written over the APB-style port only
// while no transaction is in flight; the block does not enforce it. Reset
// clears the queue and output register, ends any rectangle, loads defaults.
module clipped_color_key_blitter
  import ccb_pkg::*;
#(
  parameter int FIFO_DEPTH_P = FIFO_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  input  logic               push,
  output logic               full,
  input  req_t               req,
  output logic               empty,
  input  logic               pop,
  output resp_t              resp
);

  cfg_t   cfg;
  entry_t wr_entry;
  entry_t rd_entry;
  logic   wr_en;
  logic   fifo_empty;
  logic   fifo_rd;

  ccb_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ccb_front u_front (
    .req   (req),
    .push  (push),
    .cfg   (cfg),
    .wr_en (wr_en),
    .entry (wr_entry)
  );

  ccb_fifo #(
    .DEPTH (FIFO_DEPTH_P)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_data (wr_entry),
    .full    (full),
    .rd_en   (fifo_rd),
    .rd_data (rd_entry),
    .empty   (fifo_empty)
  );

  ccb_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .entry      (rd_entry),
    .fifo_empty (fifo_empty),
    .fifo_rd    (fifo_rd),
    .resp       (resp),
    .empty      (empty),
    .pop        (pop)
  );

endmodule
